@@ hw/rtl/swfr_pkg.sv @@
// shared types and constants of the stop-and-wait frame receiver
package swfr_pkg;

  localparam int ByteW   = 8;
  localparam int KindW   = 3;
  localparam int LenW    = 6;
  localparam int CfgIdxW = 3;

  // result kinds
  localparam logic [KindW-1:0] KIND_DATA = 3'd0;
  localparam logic [KindW-1:0] KIND_RR   = 3'd1;
  localparam logic [KindW-1:0] KIND_DUP  = 3'd2;
  localparam logic [KindW-1:0] KIND_REJ  = 3'd3;
  localparam logic [KindW-1:0] KIND_DISC = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FLAG      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ESC_FLAG  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ESC_ESC   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ADDRESS   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_INFO0     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_INFO1     = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_DISC      = 3'd7;

  // configuration reset values
  localparam logic [ByteW-1:0] RST_FLAG     = 8'd126;
  localparam logic [ByteW-1:0] RST_ESCAPE   = 8'd125;
  localparam logic [ByteW-1:0] RST_ESC_FLAG = 8'd94;
  localparam logic [ByteW-1:0] RST_ESC_ESC  = 8'd93;
  localparam logic [ByteW-1:0] RST_ADDRESS  = 8'd3;
  localparam logic [ByteW-1:0] RST_INFO0    = 8'd0;
  localparam logic [ByteW-1:0] RST_INFO1    = 8'd64;
  localparam logic [ByteW-1:0] RST_DISC     = 8'd11;

  typedef struct packed {
    logic [ByteW-1:0] flag;
    logic [ByteW-1:0] escape;
    logic [ByteW-1:0] esc_flag_code;
    logic [ByteW-1:0] esc_esc_code;
    logic [ByteW-1:0] address;
    logic [ByteW-1:0] info0;
    logic [ByteW-1:0] info1;
    logic [ByteW-1:0] disc;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data_byte;
    logic             ack_number;
    logic [LenW-1:0]  payload_length;
    logic             last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic update;        // item transfer: advance frame state
    logic load_main;     // new result into output register
    logic load_skid;     // new result into skid register
    logic skid_to_main;  // skid register moves to output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;          // current item yields a result
  } sts_t;

endpackage

@@ hw/rtl/swfr_if.sv @@
// channel interfaces: input items, results and configuration writes
interface swfr_item_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [swfr_pkg::ByteW-1:0]  rx_byte;
  modport source (output valid, req_type, rx_byte, input ready);
  modport sink   (input valid, req_type, rx_byte, output ready);
endinterface

interface swfr_result_if;
  logic                        valid;
  logic                        ready;
  logic [swfr_pkg::KindW-1:0]  result_kind;
  logic [swfr_pkg::ByteW-1:0]  data_byte;
  logic                        ack_number;
  logic [swfr_pkg::LenW-1:0]   payload_length;
  logic                        last;
  modport source (output valid, result_kind, data_byte, ack_number, payload_length, last,
                  input ready);
  modport sink   (input valid, result_kind, data_byte, ack_number, payload_length, last,
                  output ready);
endinterface

interface swfr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [swfr_pkg::CfgIdxW-1:0]  index;
  logic [swfr_pkg::ByteW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/swfr_ctrl.sv @@
// controller: output buffer occupancy and handshake sequencing
module swfr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  swfr_pkg::sts_t   sts_i,
  output swfr_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    OCC_EMPTY = 3'b001,
    OCC_ONE   = 3'b010,
    OCC_TWO   = 3'b100
  } occ_e;

  occ_e state_q, state_d;
  logic accept, push, pop;

  assign item_ready_o = (state_q != OCC_TWO);
  assign out_valid_o  = (state_q != OCC_EMPTY);
  assign accept       = item_valid_i & item_ready_o;
  assign push         = accept & sts_i.emit;
  assign pop          = out_valid_o & out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.update = accept;
    case (state_q)
      OCC_EMPTY: begin
        if (push) begin
          cmd_o.load_main = 1'b1;
          state_d = OCC_ONE;
        end
      end
      OCC_ONE: begin
        if (push && pop) begin
          cmd_o.load_main = 1'b1;
        end else if (push) begin
          cmd_o.load_skid = 1'b1;
          state_d = OCC_TWO;
        end else if (pop) begin
          state_d = OCC_EMPTY;
        end
      end
      OCC_TWO: begin
        if (pop) begin
          cmd_o.skid_to_main = 1'b1;
          state_d = OCC_ONE;
        end
      end
      default: begin
        state_d = OCC_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OCC_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/swfr_datapath.sv @@
// datapath: frame parsing, destuffing, checks and result registers
module swfr_datapath #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  swfr_pkg::cfg_t              cfg_i,
  input  logic                        req_type_i,
  input  logic [swfr_pkg::ByteW-1:0]  rx_byte_i,
  input  swfr_pkg::cmd_t              cmd_i,
  output swfr_pkg::sts_t              sts_o,
  output swfr_pkg::result_t           result_o
);

  localparam int CntW = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [5:0] {
    HP_OUT  = 6'b000001,
    HP_ADDR = 6'b000010,
    HP_CTRL = 6'b000100,
    HP_BCC1 = 6'b001000,
    HP_BODY = 6'b010000,
    HP_HELD = 6'b100000
  } hpos_e;

  hpos_e                      pos_q, pos_d;
  logic [swfr_pkg::ByteW-1:0] addr_q, addr_d, ctrl_q, ctrl_d, bcc1_q, bcc1_d;
  logic [swfr_pkg::ByteW-1:0] held_q, held_d, xor_q, xor_d;
  logic                       prev_flag_q, prev_flag_d, esc_q, esc_d, ovf_q, ovf_d;
  logic                       seq_q, seq_d;
  logic [CntW-1:0]            cnt_q, cnt_d;

  swfr_pkg::result_t          res, main_q, skid_q;
  logic                       emit;

  logic                       bcc1_ok;
  logic [swfr_pkg::ByteW-1:0] exp_ctrl, dup_ctrl, held_eff, cval;
  logic                       has_held, commit, esc_code;

  assign bcc1_ok  = ((addr_q ^ ctrl_q) == bcc1_q);
  assign exp_ctrl = seq_q ? cfg_i.info1 : cfg_i.info0;
  assign dup_ctrl = seq_q ? cfg_i.info0 : cfg_i.info1;
  // pending escape at frame end counts as a literal held byte
  assign held_eff = esc_q ? cfg_i.escape : held_q;
  assign has_held = esc_q | (pos_q == HP_HELD);
  assign esc_code = esc_q & ((rx_byte_i == cfg_i.esc_flag_code) |
                             (rx_byte_i == cfg_i.esc_esc_code));
  assign commit   = esc_q | (pos_q == HP_HELD);
  assign cval     = esc_q ? cfg_i.escape : held_q;

  always_comb begin
    pos_d       = pos_q;
    addr_d      = addr_q;
    ctrl_d      = ctrl_q;
    bcc1_d      = bcc1_q;
    held_d      = held_q;
    xor_d       = xor_q;
    prev_flag_d = prev_flag_q;
    esc_d       = esc_q;
    ovf_d       = ovf_q;
    cnt_d       = cnt_q;
    seq_d       = seq_q;
    emit        = 1'b0;
    res         = '0;
    res.last    = 1'b1;

    if (req_type_i || (rx_byte_i == cfg_i.flag)) begin
      // any delimiter or timeout drops the frame context
      pos_d       = HP_OUT;
      addr_d      = '0;
      ctrl_d      = '0;
      bcc1_d      = '0;
      held_d      = '0;
      xor_d       = '0;
      prev_flag_d = 1'b0;
      esc_d       = 1'b0;
      ovf_d       = 1'b0;
      cnt_d       = '0;
      if (req_type_i) begin
        emit           = 1'b1;
        res.kind       = swfr_pkg::KIND_REJ;
        res.ack_number = seq_q;
      end else if ((pos_q == HP_OUT) || prev_flag_q) begin
        pos_d       = HP_ADDR;
        prev_flag_d = 1'b1;
      end else begin
        emit           = 1'b1;
        res.kind       = swfr_pkg::KIND_REJ;
        res.ack_number = seq_q;
        if ((pos_q != HP_BODY) && (pos_q != HP_HELD)) begin
          res.kind = swfr_pkg::KIND_REJ;
        end else if (!bcc1_ok) begin
          res.kind = swfr_pkg::KIND_REJ;
        end else if (!has_held) begin
          if ((addr_q == cfg_i.address) && (ctrl_q == cfg_i.disc)) begin
            res.kind       = swfr_pkg::KIND_DISC;
            res.ack_number = 1'b0;
          end
        end else if (ovf_q || (xor_q != held_eff)) begin
          res.kind = swfr_pkg::KIND_REJ;
        end else if (ctrl_q == exp_ctrl) begin
          seq_d              = ~seq_q;
          res.kind           = swfr_pkg::KIND_RR;
          res.ack_number     = ~seq_q;
          res.payload_length = swfr_pkg::LenW'(cnt_q);
        end else if (ctrl_q == dup_ctrl) begin
          res.kind = swfr_pkg::KIND_DUP;
        end
      end
    end else if (pos_q != HP_OUT) begin
      prev_flag_d = 1'b0;
      case (pos_q)
        HP_ADDR: begin
          addr_d = rx_byte_i;
          pos_d  = HP_CTRL;
        end
        HP_CTRL: begin
          ctrl_d = rx_byte_i;
          pos_d  = HP_BCC1;
        end
        HP_BCC1: begin
          bcc1_d = rx_byte_i;
          pos_d  = HP_BODY;
        end
        default: begin
          if (esc_code) begin
            // flag meaning wins when both codes match
            esc_d  = 1'b0;
            held_d = (rx_byte_i == cfg_i.esc_flag_code) ? cfg_i.flag : cfg_i.escape;
            pos_d  = HP_HELD;
          end else begin
            if (commit) begin
              if (cnt_q < CntW'(MAX_PAYLOAD)) begin
                xor_d = xor_q ^ cval;
                cnt_d = cnt_q + CntW'(1);
                if (bcc1_ok && (ctrl_q == exp_ctrl)) begin
                  emit          = 1'b1;
                  res.kind      = swfr_pkg::KIND_DATA;
                  res.data_byte = cval;
                end
              end else begin
                ovf_d = 1'b1;
              end
            end
            if (rx_byte_i == cfg_i.escape) begin
              esc_d = 1'b1;
              pos_d = HP_BODY;
            end else begin
              esc_d  = 1'b0;
              held_d = rx_byte_i;
              pos_d  = HP_HELD;
            end
          end
        end
      endcase
    end
  end

  assign sts_o.emit = emit;
  assign result_o   = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= HP_OUT;
      addr_q      <= '0;
      ctrl_q      <= '0;
      bcc1_q      <= '0;
      held_q      <= '0;
      xor_q       <= '0;
      prev_flag_q <= 1'b0;
      esc_q       <= 1'b0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      seq_q       <= 1'b0;
    end else if (cmd_i.update) begin
      pos_q       <= pos_d;
      addr_q      <= addr_d;
      ctrl_q      <= ctrl_d;
      bcc1_q      <= bcc1_d;
      held_q      <= held_d;
      xor_q       <= xor_d;
      prev_flag_q <= prev_flag_d;
      esc_q       <= esc_d;
      ovf_q       <= ovf_d;
      cnt_q       <= cnt_d;
      seq_q       <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_main) begin
      main_q <= res;
    end else if (cmd_i.skid_to_main) begin
      main_q <= skid_q;
    end
    if (cmd_i.load_skid) begin
      skid_q <= res;
    end
  end

endmodule

@@ hw/rtl/stop_and_wait_frame_receiver_core.sv @@
// top level of the stop-and-wait frame receiver
//
//  channel   | dir | payload                                          | transfer when
//  ----------+-----+--------------------------------------------------+---------------
//  item_i    | in  | req_type, rx_byte                                | valid && ready
//  result_o  | out | result_kind, data_byte, ack_number,              | valid && ready
//            |     | payload_length, last                             |
//  cfg_i     | in  | index, data                                      | valid && ready
//
//  one input item is taken per cycle while item_i.ready is high; its result, if any, shows on result_o in the
//  next cycle when the output register is empty or drains at that edge, else it
//  waits in a skid register behind the output register until the output drains
//  item_i.ready drops only when both registers are full
//  cfg_i is always ready; reset restores the default delimiter, escape,
//  address and control values and puts the receiver outside a frame
module stop_and_wait_frame_receiver_core #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  swfr_item_if.sink      item_i,
  swfr_result_if.source  result_o,
  swfr_cfg_if.sink       cfg_i
);

  swfr_pkg::cfg_t    cfg_q;
  swfr_pkg::cmd_t    cmd;
  swfr_pkg::sts_t    sts;
  swfr_pkg::result_t res;

  // configuration register file, to be written only between frames; the block leaves this to the user
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag          <= swfr_pkg::RST_FLAG;
      cfg_q.escape        <= swfr_pkg::RST_ESCAPE;
      cfg_q.esc_flag_code <= swfr_pkg::RST_ESC_FLAG;
      cfg_q.esc_esc_code  <= swfr_pkg::RST_ESC_ESC;
      cfg_q.address       <= swfr_pkg::RST_ADDRESS;
      cfg_q.info0         <= swfr_pkg::RST_INFO0;
      cfg_q.info1         <= swfr_pkg::RST_INFO1;
      cfg_q.disc          <= swfr_pkg::RST_DISC;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        swfr_pkg::CFG_FLAG:     cfg_q.flag          <= cfg_i.data;
        swfr_pkg::CFG_ESCAPE:   cfg_q.escape        <= cfg_i.data;
        swfr_pkg::CFG_ESC_FLAG: cfg_q.esc_flag_code <= cfg_i.data;
        swfr_pkg::CFG_ESC_ESC:  cfg_q.esc_esc_code  <= cfg_i.data;
        swfr_pkg::CFG_ADDRESS:  cfg_q.address       <= cfg_i.data;
        swfr_pkg::CFG_INFO0:    cfg_q.info0         <= cfg_i.data;
        swfr_pkg::CFG_INFO1:    cfg_q.info1         <= cfg_i.data;
        swfr_pkg::CFG_DISC:     cfg_q.disc          <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // handshake sequencing and buffer occupancy
  swfr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_i.ready),
    .out_valid_o  (result_o.valid),
    .out_ready_i  (result_o.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // frame state, destuffing, checks and result registers
  swfr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .req_type_i (item_i.req_type),
    .rx_byte_i  (item_i.rx_byte),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .result_o   (res)
  );

  assign result_o.result_kind    = res.kind;
  assign result_o.data_byte      = res.data_byte;
  assign result_o.ack_number     = res.ack_number;
  assign result_o.payload_length = res.payload_length;
  assign result_o.last           = res.last;

  // a full buffer must be visible at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_i.ready |-> result_o.valid)
    else $error("input stalled with no result pending");

  // a timeout always produces a reply
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready && item_i.req_type) |=> result_o.valid)
    else $error("timeout transfer gave no result");

  // length only travels with an accepted RR
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.result_kind != swfr_pkg::KIND_RR))
      |-> (result_o.payload_length == '0))
    else $error("payload length on a non-RR result");

endmodule
